// ===== src/mfuf_pkg.sv =====
// Shared types, widths and constants of the motor feedback unwrap filter.
package mfuf_pkg;

   // Item field widths
   localparam int unsigned POS_WIDTH     = 14;
   localparam int unsigned RPM_WIDTH     = 16;
   localparam int unsigned CUR_WIDTH     = 16;
   localparam int unsigned TEMP_WIDTH    = 8;
   localparam int unsigned COUNT_WIDTH   = 32;
   localparam int unsigned TURNS_WIDTH   = 19;
   localparam int unsigned ANGLE_WIDTH   = 15;
   localparam int unsigned SPEED_WIDTH   = 24;

   // Register widths
   localparam int unsigned LAP_BITS_WIDTH = 4;
   localparam int unsigned COEF_WIDTH     = 17;
   localparam int unsigned DPS_WIDTH      = 4;
   localparam int unsigned LIMIT_WIDTH    = 8;

   // Configuration port
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_LAP_BITS     = 3'd0,
      REG_SPEED_COEF   = 3'd1,
      REG_CURRENT_COEF = 3'd2,
      REG_RPM_TO_DPS   = 3'd3,
      REG_TEMP_LIMIT   = 3'd4
   } reg_index_type;

   // Register reset values
   localparam logic [LAP_BITS_WIDTH-1:0] LAP_BITS_RESET   = 4'd13;
   localparam logic [COEF_WIDTH-1:0]     COEF_RESET       = 17'h10000;
   localparam logic [DPS_WIDTH-1:0]      RPM_TO_DPS_RESET = 4'd6;
   localparam logic [LIMIT_WIDTH-1:0]    TEMP_LIMIT_RESET = 8'd60;

   // lap_bits value that selects the 16384-count lap; anything else is 8192
   localparam logic [LAP_BITS_WIDTH-1:0] LAP_BITS_WIDE = 4'd14;

   // Q16 unity
   localparam logic [COEF_WIDTH-1:0] Q16_ONE = 17'h10000;

   // Shared multiplier operand widths
   localparam int unsigned MUL_A_WIDTH = 25;
   localparam int unsigned MUL_B_WIDTH = 18;
   localparam int unsigned MUL_P_WIDTH = MUL_A_WIDTH + MUL_B_WIDTH;

   // 360 degrees * 64
   localparam logic [MUL_B_WIDTH-1:0] ANGLE_SCALE = 18'd23040;

   typedef struct packed {
      logic [LAP_BITS_WIDTH-1:0] lap_bits;
      logic [COEF_WIDTH-1:0]     speed_coef;
      logic [COEF_WIDTH-1:0]     current_coef;
      logic [DPS_WIDTH-1:0]      rpm_to_dps;
      logic [LIMIT_WIDTH-1:0]    temp_limit;
   } cfg_type;

endpackage

// ===== src/mfuf_if.sv =====
// Item channel interfaces: feedback frame in, filtered result out.
interface mfuf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [mfuf_pkg::POS_WIDTH-1:0]  encoder_pos;
   logic signed [mfuf_pkg::RPM_WIDTH-1:0]  speed_rpm;
   logic signed [mfuf_pkg::CUR_WIDTH-1:0]  current_raw;
   logic        [mfuf_pkg::TEMP_WIDTH-1:0] temperature;

   modport source (output valid, encoder_pos, speed_rpm, current_raw, temperature,
                   input ready);
   modport sink   (input valid, encoder_pos, speed_rpm, current_raw, temperature,
                   output ready);
endinterface

interface mfuf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mfuf_pkg::COUNT_WIDTH-1:0] multi_turn_count;
   logic signed [mfuf_pkg::TURNS_WIDTH-1:0] whole_turns;
   logic        [mfuf_pkg::ANGLE_WIDTH-1:0] angle_sixtyfourths;
   logic signed [mfuf_pkg::SPEED_WIDTH-1:0] speed_filtered;
   logic signed [mfuf_pkg::CUR_WIDTH-1:0]   current_filtered;
   logic                                  over_temp;
   logic                                  first_frame;

   modport source (output valid, multi_turn_count, whole_turns, angle_sixtyfourths,
                   speed_filtered, current_filtered, over_temp, first_frame,
                   input ready);
   modport sink   (input valid, multi_turn_count, whole_turns, angle_sixtyfourths,
                   speed_filtered, current_filtered, over_temp, first_frame,
                   output ready);
endinterface

// ===== src/mfuf_mul.sv =====
// Shared signed multiplier with registered product.
module mfuf_mul (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [mfuf_pkg::MUL_A_WIDTH-1:0] op_a,
   input  logic signed [mfuf_pkg::MUL_B_WIDTH-1:0] op_b,
   output logic signed [mfuf_pkg::MUL_P_WIDTH-1:0] product
);

   logic signed [mfuf_pkg::MUL_P_WIDTH-1:0] product_ff;
   logic signed [mfuf_pkg::MUL_P_WIDTH-1:0] product_in;

   always_comb begin
      product_in = product_ff;
      if (enable) begin
         product_in = op_a * op_b;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== src/mfuf_csr.sv =====
// APB-style register file for the filter configuration.
module mfuf_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mfuf_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [mfuf_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [mfuf_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output mfuf_pkg::cfg_type                      cfg
);

   mfuf_pkg::cfg_type cfg_ff;
   mfuf_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            mfuf_pkg::REG_LAP_BITS: begin
               cfg_in.lap_bits = csr_pwdata[mfuf_pkg::LAP_BITS_WIDTH-1:0];
            end
            mfuf_pkg::REG_SPEED_COEF: begin
               cfg_in.speed_coef = csr_pwdata[mfuf_pkg::COEF_WIDTH-1:0];
            end
            mfuf_pkg::REG_CURRENT_COEF: begin
               cfg_in.current_coef = csr_pwdata[mfuf_pkg::COEF_WIDTH-1:0];
            end
            mfuf_pkg::REG_RPM_TO_DPS: begin
               cfg_in.rpm_to_dps = csr_pwdata[mfuf_pkg::DPS_WIDTH-1:0];
            end
            mfuf_pkg::REG_TEMP_LIMIT: begin
               cfg_in.temp_limit = csr_pwdata[mfuf_pkg::LIMIT_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         mfuf_pkg::REG_LAP_BITS: begin
            csr_prdata = {28'd0, cfg_ff.lap_bits};
         end
         mfuf_pkg::REG_SPEED_COEF: begin
            csr_prdata = {15'd0, cfg_ff.speed_coef};
         end
         mfuf_pkg::REG_CURRENT_COEF: begin
            csr_prdata = {15'd0, cfg_ff.current_coef};
         end
         mfuf_pkg::REG_RPM_TO_DPS: begin
            csr_prdata = {28'd0, cfg_ff.rpm_to_dps};
         end
         mfuf_pkg::REG_TEMP_LIMIT: begin
            csr_prdata = {24'd0, cfg_ff.temp_limit};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lap_bits     <= mfuf_pkg::LAP_BITS_RESET;
         cfg_ff.speed_coef   <= mfuf_pkg::COEF_RESET;
         cfg_ff.current_coef <= mfuf_pkg::COEF_RESET;
         cfg_ff.rpm_to_dps   <= mfuf_pkg::RPM_TO_DPS_RESET;
         cfg_ff.temp_limit   <= mfuf_pkg::TEMP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/motor_feedback_unwrap_filter_top.sv =====
// Top level: multi-turn encoder unwrap with speed and current smoothing.
// An accepted item passes through ST_ANGLE, ST_TGT, ST_SPD, ST_CUR and ST_DONE;
// ST_DONE registers the result once the output register is free. A new item
// is taken only in ST_IDLE; each takes four passes through the one shared
// 25x18 multiplier (angle, speed target, speed average, current average).
// Reset (synchronous, active high) restores register defaults and clears the
// multi-turn count, both averages and the seeded flag; the next item seeds.
module motor_feedback_unwrap_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   mfuf_req_if.sink                            req_ch,
   mfuf_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mfuf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mfuf_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [mfuf_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   // Sequencer: each MUL state drives the shared multiplier; the product is
   // consumed by the following state.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ANGLE = 6'b000010,  // pos * 23040; also unwrap and count update
      ST_TGT   = 6'b000100,  // rpm * rpm_to_dps; angle taken from product
      ST_SPD   = 6'b001000,  // speed_coef * (target - speed_avg)
      ST_CUR   = 6'b010000,  // current_coef * (current - current_avg)
      ST_DONE  = 6'b100000   // current average, result into output register
   } state_type;

   mfuf_pkg::cfg_type cfg;

   mfuf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type state_ff, state_in;

   // Latched item
   logic [mfuf_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [mfuf_pkg::RPM_WIDTH-1:0]  rpm_ff, rpm_in;
   logic [mfuf_pkg::CUR_WIDTH-1:0]  cur_ff, cur_in;
   logic [mfuf_pkg::TEMP_WIDTH-1:0] temp_ff, temp_in;
   logic                            first_ff, first_in;

   // Tracking state
   logic                             seeded_ff, seeded_in;
   logic [mfuf_pkg::POS_WIDTH-1:0]   last_pos_ff, last_pos_in;
   logic [mfuf_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [mfuf_pkg::SPEED_WIDTH-1:0] speed_avg_ff, speed_avg_in;
   logic [mfuf_pkg::CUR_WIDTH-1:0]   cur_avg_ff, cur_avg_in;
   logic [mfuf_pkg::ANGLE_WIDTH-1:0] angle_ff, angle_in;

   // Output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mfuf_pkg::COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic [mfuf_pkg::TURNS_WIDTH-1:0] rsp_turns_ff, rsp_turns_in;
   logic [mfuf_pkg::ANGLE_WIDTH-1:0] rsp_angle_ff, rsp_angle_in;
   logic [mfuf_pkg::SPEED_WIDTH-1:0] rsp_speed_ff, rsp_speed_in;
   logic [mfuf_pkg::CUR_WIDTH-1:0]   rsp_cur_ff, rsp_cur_in;
   logic                             rsp_over_ff, rsp_over_in;
   logic                             rsp_first_ff, rsp_first_in;

   // Shared multiplier
   logic                                    mul_en;
   logic signed [mfuf_pkg::MUL_A_WIDTH-1:0] mul_a;
   logic signed [mfuf_pkg::MUL_B_WIDTH-1:0] mul_b;
   logic signed [mfuf_pkg::MUL_P_WIDTH-1:0] prod;

   mfuf_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // Lap selection: 16384 counts only for lap_bits == 14
   logic                           lap_wide;
   logic [mfuf_pkg::POS_WIDTH-1:0] lap_mask;
   assign lap_wide = (cfg.lap_bits == mfuf_pkg::LAP_BITS_WIDE);
   assign lap_mask = lap_wide ? 14'h3FFF : 14'h1FFF;

   // Coefficients above unity act as unity
   logic [mfuf_pkg::COEF_WIDTH-1:0] speed_c, cur_c;
   assign speed_c = (cfg.speed_coef > mfuf_pkg::Q16_ONE) ? mfuf_pkg::Q16_ONE : cfg.speed_coef;
   assign cur_c   = (cfg.current_coef > mfuf_pkg::Q16_ONE) ? mfuf_pkg::Q16_ONE
                                                           : cfg.current_coef;

   // Position unwrap: delta folded into +/- half a lap, half a lap kept as is
   logic signed [15:0] delta_raw, delta;
   logic signed [15:0] half_lap, full_lap;
   logic        [32:0] count_sum;
   logic        [mfuf_pkg::COUNT_WIDTH-1:0] count_sat;

   always_comb begin
      half_lap  = lap_wide ? 16'sd8192 : 16'sd4096;
      full_lap  = lap_wide ? 16'sd16384 : 16'sd8192;
      delta_raw = $signed({2'b00, pos_ff}) - $signed({2'b00, last_pos_ff & lap_mask});
      if (first_ff) begin
         delta = 16'sd0;
      end else if (delta_raw > half_lap) begin
         delta = delta_raw - full_lap;
      end else if (delta_raw < -half_lap) begin
         delta = delta_raw + full_lap;
      end else begin
         delta = delta_raw;
      end
      count_sum = {count_ff[31], count_ff} + {{17{delta[15]}}, delta};
      if (count_sum[32] != count_sum[31]) begin
         count_sat = count_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         count_sat = count_sum[31:0];
      end
   end

   // Speed target in Q4 deg/s comes straight from the rpm product
   logic [mfuf_pkg::SPEED_WIDTH-1:0] speed_tgt;
   logic [mfuf_pkg::MUL_A_WIDTH-1:0] speed_diff;
   logic [mfuf_pkg::CUR_WIDTH:0]     cur_diff;
   assign speed_tgt  = {prod[19:0], 4'b0000};
   assign speed_diff = {speed_tgt[23], speed_tgt} - {speed_avg_ff[23], speed_avg_ff};
   assign cur_diff   = {cur_ff[15], cur_ff} - {cur_avg_ff[15], cur_avg_ff};

   // New average = avg + c*(target - avg), rounded half up, floor by shift.
   // The result lies between avg and target, so it never leaves the field range.
   logic [43:0] speed_acc, cur_acc;
   assign speed_acc = {{4{speed_avg_ff[23]}}, speed_avg_ff, 16'h0000}
                    + {prod[42], prod} + 44'd32768;
   assign cur_acc   = {{12{cur_avg_ff[15]}}, cur_avg_ff, 16'h0000}
                    + {prod[42], prod} + 44'd32768;

   logic out_free;
   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      rpm_in       = rpm_ff;
      cur_in       = cur_ff;
      temp_in      = temp_ff;
      first_in     = first_ff;
      seeded_in    = seeded_ff;
      last_pos_in  = last_pos_ff;
      count_in     = count_ff;
      speed_avg_in = speed_avg_ff;
      cur_avg_in   = cur_avg_ff;
      angle_in     = angle_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_count_in = rsp_count_ff;
      rsp_turns_in = rsp_turns_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_first_in = rsp_first_ff;

      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               pos_in   = req_ch.encoder_pos & lap_mask;
               rpm_in   = req_ch.speed_rpm;
               cur_in   = req_ch.current_raw;
               temp_in  = req_ch.temperature;
               first_in = ~seeded_ff;
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            mul_en      = 1'b1;
            mul_a       = $signed({11'd0, pos_ff});
            mul_b       = mfuf_pkg::ANGLE_SCALE;
            seeded_in   = 1'b1;
            last_pos_in = pos_ff;
            count_in    = count_sat;
            state_in    = ST_TGT;
         end
         ST_TGT: begin
            // pos*23040 stays below 2^29
            angle_in = lap_wide ? prod[28:14] : prod[27:13];
            mul_en   = 1'b1;
            mul_a    = $signed({{9{rpm_ff[15]}}, rpm_ff});
            mul_b    = $signed({14'd0, cfg.rpm_to_dps});
            state_in = ST_SPD;
         end
         ST_SPD: begin
            mul_en   = 1'b1;
            mul_a    = $signed(speed_diff);
            mul_b    = $signed({1'b0, speed_c});
            state_in = ST_CUR;
         end
         ST_CUR: begin
            speed_avg_in = speed_acc[39:16];
            mul_en       = 1'b1;
            mul_a        = $signed({{8{cur_diff[16]}}, cur_diff});
            mul_b        = $signed({1'b0, cur_c});
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // Hold here until the output register can take the result
            if (out_free) begin
               cur_avg_in   = cur_acc[31:16];
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               // Floor of count / lap is an arithmetic shift
               rsp_turns_in = lap_wide ? {count_ff[31], count_ff[31:14]} : count_ff[31:13];
               rsp_angle_in = angle_ff;
               rsp_speed_in = speed_avg_ff;
               rsp_cur_in   = cur_acc[31:16];
               rsp_over_in  = (temp_ff > cfg.temp_limit);
               rsp_first_in = first_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         last_pos_ff  <= '0;
         count_ff     <= '0;
         speed_avg_ff <= '0;
         cur_avg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         last_pos_ff  <= last_pos_in;
         count_ff     <= count_in;
         speed_avg_ff <= speed_avg_in;
         cur_avg_ff   <= cur_avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      rpm_ff       <= rpm_in;
      cur_ff       <= cur_in;
      temp_ff      <= temp_in;
      first_ff     <= first_in;
      angle_ff     <= angle_in;
      rsp_count_ff <= rsp_count_in;
      rsp_turns_ff <= rsp_turns_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_first_ff <= rsp_first_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.multi_turn_count   = rsp_count_ff;
   assign rsp_ch.whole_turns        = rsp_turns_ff;
   assign rsp_ch.angle_sixtyfourths = rsp_angle_ff;
   assign rsp_ch.speed_filtered     = rsp_speed_ff;
   assign rsp_ch.current_filtered   = rsp_cur_ff;
   assign rsp_ch.over_temp          = rsp_over_ff;
   assign rsp_ch.first_frame        = rsp_first_ff;

endmodule
